// ===== src/rtpv_pkg.sv =====
// rtpv_pkg: shared types, constants and register codes for the rigid transform block
// used by every module of rigid_transform_point_vector; no dependencies

package rtpv_pkg;

  localparam int COORD_W          = 32;
  localparam int MAT_W            = 16;
  localparam int MATRIX_FRAC_BITS = 14;
  localparam int ROW_W            = 3 * MAT_W;
  localparam int A_W              = COORD_W + 1;
  localparam int PROD_W           = MAT_W + A_W;
  localparam int ACC_W            = PROD_W + 2;
  localparam int ROT_W            = ACC_W - MATRIX_FRAC_BITS;
  localparam int POST_W           = ROT_W + 1;
  localparam int FIFO_DEPTH       = 4;
  localparam int FIFO_AW          = $clog2(FIFO_DEPTH);
  localparam int CFG_IDX_W        = 3;

  localparam logic [MAT_W-1:0] MAT_ONE = MAT_W'(1) << MATRIX_FRAC_BITS;

  typedef enum logic [1:0] {
    OP_FWD_POINT = 2'd0,
    OP_FWD_VEC   = 2'd1,
    OP_INV_POINT = 2'd2,
    OP_INV_VEC   = 2'd3
  } rtpv_op_t;

  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BEAM_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_Z    = 3'd6;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [A_W-1:0]     acoord_t;

  typedef struct packed {
    logic [2:0][ROW_W-1:0]   rot;
    logic [COORD_W-1:0]      zb;
    logic [2:0][COORD_W-1:0] tgt;
  } rtpv_cfg_t;

  typedef struct packed {
    rtpv_op_t            op;
    logic [2:0][A_W-1:0] a;
  } rtpv_item_t;

endpackage

// ===== src/rtpv_cfg.sv =====
// rtpv_cfg: configuration register file (rotation rows, beam offset, target point)
// depends on rtpv_pkg

module rtpv_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rtpv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rtpv_pkg::ROW_W-1:0]    cfg_data,
  output rtpv_pkg::rtpv_cfg_t           cfg_o
);
  import rtpv_pkg::*;

  rtpv_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rot[0] <= {{(2*MAT_W){1'b0}}, MAT_ONE};
      cfg_r.rot[1] <= {{MAT_W{1'b0}}, MAT_ONE, {MAT_W{1'b0}}};
      cfg_r.rot[2] <= {MAT_ONE, {(2*MAT_W){1'b0}}};
      cfg_r.zb     <= '0;
      cfg_r.tgt    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROT_ROW0:    cfg_r.rot[0] <= cfg_data;
        REG_ROT_ROW1:    cfg_r.rot[1] <= cfg_data;
        REG_ROT_ROW2:    cfg_r.rot[2] <= cfg_data;
        REG_BEAM_OFFSET: cfg_r.zb     <= cfg_data[COORD_W-1:0];
        REG_TARGET_X:    cfg_r.tgt[0] <= cfg_data[COORD_W-1:0];
        REG_TARGET_Y:    cfg_r.tgt[1] <= cfg_data[COORD_W-1:0];
        REG_TARGET_Z:    cfg_r.tgt[2] <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/rtpv_front.sv =====
// rtpv_front: accepts requests, decodes the mode and forms the pre-rotation vector
// depends on rtpv_pkg

module rtpv_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_op,
  input  logic [3*rtpv_pkg::COORD_W-1:0] in_data,
  input  rtpv_pkg::rtpv_cfg_t      cfg_i,
  output logic                     push,
  output rtpv_pkg::rtpv_item_t     push_item,
  input  logic                     full
);
  import rtpv_pkg::*;

  logic       valid_r;
  rtpv_item_t item_r;
  rtpv_item_t item_nxt;
  acoord_t    qx, qy, qz, zb;
  acoord_t    tx, ty, tz;

  assign push      = valid_r && !full;
  assign push_item = item_r;
  assign in_ready  = !valid_r || !full;

  always_comb begin
    qx = A_W'($signed(in_data[COORD_W-1:0]));
    qy = A_W'($signed(in_data[2*COORD_W-1:COORD_W]));
    qz = A_W'($signed(in_data[3*COORD_W-1:2*COORD_W]));
    zb = A_W'($signed(cfg_i.zb));
    tx = A_W'($signed(cfg_i.tgt[0]));
    ty = A_W'($signed(cfg_i.tgt[1]));
    tz = A_W'($signed(cfg_i.tgt[2]));
    item_nxt.op = rtpv_op_t'(in_op);
    unique case (rtpv_op_t'(in_op))
      OP_FWD_POINT: begin
        item_nxt.a[0] = -qx;
        item_nxt.a[1] = -qy;
        item_nxt.a[2] = zb - qz;
      end
      OP_FWD_VEC: begin
        item_nxt.a[0] = -qx;
        item_nxt.a[1] = -qy;
        item_nxt.a[2] = -qz;
      end
      OP_INV_POINT: begin
        item_nxt.a[0] = qx - tx;
        item_nxt.a[1] = qy - ty;
        item_nxt.a[2] = qz - tz;
      end
      default: begin
        item_nxt.a[0] = qx;
        item_nxt.a[1] = qy;
        item_nxt.a[2] = qz;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== src/rtpv_fifo.sv =====
// rtpv_fifo: short request queue between the front and back sections
// depends on rtpv_pkg

module rtpv_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rtpv_pkg::rtpv_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output rtpv_pkg::rtpv_item_t head
);
  import rtpv_pkg::*;

  rtpv_item_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wptr_r, rptr_r;
  logic [FIFO_AW:0]       count_r;

  assign full  = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= push_item;
    end
  end

endmodule

// ===== src/rtpv_back.sv =====
// rtpv_back: multiply, sum and round, offset and saturate pipeline with output register
// depends on rtpv_pkg

module rtpv_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rtpv_pkg::rtpv_cfg_t      cfg_i,
  input  logic                     empty,
  input  rtpv_pkg::rtpv_item_t     head,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [3*rtpv_pkg::COORD_W-1:0] out_data,
  output logic                     out_sat
);
  import rtpv_pkg::*;

  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (MATRIX_FRAC_BITS - 1);
  localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  logic en;

  // multiply stage
  logic                                  s1_valid_r;
  rtpv_op_t                              s1_op_r;
  logic signed [PROD_W-1:0]              s1_p_r   [3][3];
  logic signed [PROD_W-1:0]              s1_p_nxt [3][3];
  logic signed [MAT_W-1:0]               m        [3][3];
  logic                                  trans;

  // sum and round stage
  logic                                  s2_valid_r;
  rtpv_op_t                              s2_op_r;
  logic signed [ROT_W-1:0]               s2_r_r   [3];
  logic signed [ROT_W-1:0]               s2_r_nxt [3];
  logic signed [ACC_W-1:0]               acc      [3];

  // offset stage
  logic                                  s3_valid_r;
  logic signed [POST_W-1:0]              s3_v_r   [3];
  logic signed [POST_W-1:0]              s3_v_nxt [3];
  logic signed [POST_W-1:0]              add      [3];
  logic                                  neg;

  // output register
  logic                                  out_valid_r;
  logic [2:0][COORD_W-1:0]               out_c_r, out_c_nxt;
  logic                                  out_sat_r, out_sat_nxt;
  logic [POST_W-COORD_W:0]               hi;

  assign en        = !out_valid_r || out_ready;
  assign pop       = en && !empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_c_r;
  assign out_sat   = out_sat_r;

  always_comb begin
    trans = (head.op == OP_INV_POINT) || (head.op == OP_INV_VEC);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m[i][j] = trans ? $signed(cfg_i.rot[j][MAT_W*i +: MAT_W])
                        : $signed(cfg_i.rot[i][MAT_W*j +: MAT_W]);
        s1_p_nxt[i][j] = m[i][j] * $signed(head.a[j]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = ACC_W'(s1_p_r[i][0]) + ACC_W'(s1_p_r[i][1]) + ACC_W'(s1_p_r[i][2]) + RND;
      s2_r_nxt[i] = ROT_W'(acc[i] >>> MATRIX_FRAC_BITS);
    end
  end

  always_comb begin
    neg = (s2_op_r == OP_INV_POINT) || (s2_op_r == OP_INV_VEC);
    for (int i = 0; i < 3; i++) add[i] = '0;
    unique case (s2_op_r)
      OP_FWD_POINT: begin
        for (int i = 0; i < 3; i++) add[i] = POST_W'($signed(cfg_i.tgt[i]));
      end
      OP_INV_POINT: add[2] = POST_W'($signed(cfg_i.zb));
      default: ;
    endcase
    for (int i = 0; i < 3; i++) begin
      s3_v_nxt[i] = (neg ? -POST_W'(s2_r_r[i]) : POST_W'(s2_r_r[i])) + add[i];
    end
  end

  always_comb begin
    out_sat_nxt = 1'b0;
    hi          = '0;
    for (int i = 0; i < 3; i++) begin
      hi = s3_v_r[i][POST_W-1:COORD_W-1];
      if (hi != '0 && hi != '1) begin
        out_sat_nxt  = 1'b1;
        out_c_nxt[i] = s3_v_r[i][POST_W-1] ? SAT_MIN : SAT_MAX;
      end else begin
        out_c_nxt[i] = s3_v_r[i][COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= !empty;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op_r   <= head.op;
      s1_p_r    <= s1_p_nxt;
      s2_op_r   <= s1_op_r;
      s2_r_r    <= s2_r_nxt;
      s3_v_r    <= s3_v_nxt;
      out_c_r   <= out_c_nxt;
      out_sat_r <= out_sat_nxt;
    end
  end

endmodule

// ===== src/rigid_transform_point_vector.sv =====
// Rigid 3-D transform of Q15.16 points and directions between source and voxel frames
// with a loaded Q1.14 rotation, beam offset and target point. One request per clock is
// sustained while out_tready stays high. The front register forms the pre-rotation vector,
// a four-entry queue holds requests, and the back pipeline registers the nine 16x33
// products, the rounded row sums, the offset and the saturated result in turn.
// Output stalls fill the queue before in_tready drops. Depends on rtpv_pkg and submodules.

module rigid_transform_point_vector (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [95:0]              in_tdata,   // in_x, in_y, in_z
  input  logic [1:0]               in_tuser,   // opcode
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [95:0]              out_tdata,  // out_x, out_y, out_z
  output logic                     out_tuser,  // saturated
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [rtpv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rtpv_pkg::ROW_W-1:0]     cfg_data
);
  import rtpv_pkg::*;

  rtpv_cfg_t  cfg;
  rtpv_item_t push_item, head;
  logic       push, full, pop, empty;

  rtpv_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  rtpv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_data   (in_tdata),
    .cfg_i     (cfg),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  rtpv_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  rtpv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_i     (cfg),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_sat   (out_tuser)
  );

endmodule

// ===== tb/sv/rtpv_checker.sv =====
// rtpv_checker: watches the request, result and register channels of rigid_transform_point_vector,
// predicts every transform from its own copy of the registers and compares results in order
// depends on rtpv_pkg for the opcode enum, coordinate type and register codes
`timescale 1ns / 1ps

module rtpv_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [95:0]                   in_tdata,
  input  logic [1:0]                    in_tuser,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [95:0]                   out_tdata,
  input  logic                          out_tuser,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [rtpv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rtpv_pkg::ROW_W-1:0]     cfg_data,
  output int                            errors,
  output int                            pending,
  output int                            checked,
  output int                            clipped
);
  import rtpv_pkg::*;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] c;
    logic                    sat;
  } xform_t;

  localparam longint HALF_LSB = longint'(1) << (MATRIX_FRAC_BITS - 1);
  localparam longint C_MAX    = 64'sh0000_0000_7FFF_FFFF;
  localparam longint C_MIN    = -64'sh0000_0000_8000_0000;

  logic [ROW_W-1:0]   rot [3];
  logic [COORD_W-1:0] beam;
  logic [COORD_W-1:0] target [3];
  xform_t             pending_xforms [$];
  string              axis_name [3] = '{"x", "y", "z"};

  function automatic longint rot_entry(int r, int c);
    logic signed [MAT_W-1:0] e;
    e = rot[r][MAT_W*c +: MAT_W];
    return longint'(e);
  endfunction

  function automatic xform_t transform(rtpv_op_t op, coord_t qx, coord_t qy, coord_t qz);
    longint q [3];
    longint a [3];
    longint r [3];
    longint tg [3];
    longint zb;
    longint acc;
    bit     tr;
    xform_t res;
    q[0] = qx;
    q[1] = qy;
    q[2] = qz;
    zb = coord_t'(beam);
    for (int i = 0; i < 3; i++) tg[i] = coord_t'(target[i]);
    tr = (op == OP_INV_POINT) || (op == OP_INV_VEC);
    case (op)
      OP_FWD_POINT: begin
        a[0] = -q[0];
        a[1] = -q[1];
        a[2] = zb - q[2];
      end
      OP_FWD_VEC: begin
        for (int i = 0; i < 3; i++) a[i] = -q[i];
      end
      OP_INV_POINT: begin
        for (int i = 0; i < 3; i++) a[i] = q[i] - tg[i];
      end
      default: begin
        for (int i = 0; i < 3; i++) a[i] = q[i];
      end
    endcase
    // each row sum rounded half up to the coordinate grid
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += (tr ? rot_entry(j, i) : rot_entry(i, j)) * a[j];
      r[i] = (acc + HALF_LSB) >>> MATRIX_FRAC_BITS;
    end
    case (op)
      OP_FWD_POINT: begin
        for (int i = 0; i < 3; i++) r[i] += tg[i];
      end
      OP_FWD_VEC: begin
      end
      OP_INV_POINT: begin
        r[0] = -r[0];
        r[1] = -r[1];
        r[2] = zb - r[2];
      end
      default: begin
        for (int i = 0; i < 3; i++) r[i] = -r[i];
      end
    endcase
    res.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (r[i] > C_MAX) begin
        r[i] = C_MAX;
        res.sat = 1'b1;
      end else if (r[i] < C_MIN) begin
        r[i] = C_MIN;
        res.sat = 1'b1;
      end
      res.c[i] = r[i][COORD_W-1:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    xform_t want;
    xform_t got;
    if (!rst_n) begin
      rot[0] = ROW_W'(MAT_ONE);
      rot[1] = ROW_W'(MAT_ONE) << MAT_W;
      rot[2] = ROW_W'(MAT_ONE) << (2 * MAT_W);
      beam = '0;
      for (int i = 0; i < 3; i++) target[i] = '0;
      pending_xforms.delete();
      pending = 0;
      errors = 0;
      checked = 0;
      clipped = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROT_ROW0:    rot[0] = cfg_data;
          REG_ROT_ROW1:    rot[1] = cfg_data;
          REG_ROT_ROW2:    rot[2] = cfg_data;
          REG_BEAM_OFFSET: beam = cfg_data[COORD_W-1:0];
          REG_TARGET_X:    target[0] = cfg_data[COORD_W-1:0];
          REG_TARGET_Y:    target[1] = cfg_data[COORD_W-1:0];
          REG_TARGET_Z:    target[2] = cfg_data[COORD_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        pending_xforms.push_back(transform(rtpv_op_t'(in_tuser), in_tdata[31:0],
                                           in_tdata[63:32], in_tdata[95:64]));
      end
      if (out_tvalid && out_tready) begin
        got.c = out_tdata;
        got.sat = out_tuser;
        if (pending_xforms.size() == 0) begin
          errors++;
          $display("%0t ns: result with none expected: x %0d y %0d z %0d sat %0b", $time,
                   $signed(got.c[0]), $signed(got.c[1]), $signed(got.c[2]), got.sat);
        end else begin
          want = pending_xforms.pop_front();
          checked++;
          if (want.sat) clipped++;
          for (int i = 0; i < 3; i++) begin
            if (got.c[i] !== want.c[i]) begin
              errors++;
              $display("%0t ns: out_%s expected %0d, got %0d", $time, axis_name[i],
                       $signed(want.c[i]), $signed(got.c[i]));
            end
          end
          if (got.sat !== want.sat) begin
            errors++;
            $display("%0t ns: saturated expected %0b, got %0b", $time, want.sat, got.sat);
          end
        end
      end
      pending = pending_xforms.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: drives rigid_transform_point_vector with directed and random transforms under several
// register settings, random stalls on both sides, and gives the verdict
// depends on rtpv_pkg, the block under test and rtpv_checker
`timescale 1ns / 1ps

module tb_top;
  import rtpv_pkg::*;

  localparam int     PHASES     = 8;
  localparam int     PHASE_REQS = 104;
  localparam int     HOLD_CYCLES = 80;
  localparam int     IDLE_LIMIT = 1000;
  localparam int     SETTLE_CYCLES = 8;
  localparam coord_t C_MAX = 32'sh7FFF_FFFF;
  localparam coord_t C_MIN = 32'sh8000_0000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [95:0]          in_tdata;   // in_x, in_y, in_z
  logic [1:0]           in_tuser;   // opcode
  logic                 out_tvalid;
  logic                 out_tready;
  logic [95:0]          out_tdata;  // out_x, out_y, out_z
  logic                 out_tuser;  // saturated
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ROW_W-1:0]     cfg_data;

  int errors;
  int pending;
  int checked;
  int clipped;
  int settings;
  int idle_cycles;
  bit tx_gaps;
  bit rx_gaps;
  bit hold_req;

  rigid_transform_point_vector uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  rtpv_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked),
    .clipped    (clipped)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, or one long hold while the queue fills
  initial begin
    int n;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 8);
        repeat (n) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic logic [MAT_W-1:0] pick_entry(int kind);
    logic [MAT_W-1:0] e;
    case (kind)
      0: e = MAT_W'($urandom);
      1: e = MAT_W'($urandom_range(0, 32768) - 16384);
      default:
        case ($urandom_range(0, 4))
          0: e = 16'h8000;
          1: e = 16'h7FFF;
          2: e = MAT_ONE;
          3: e = -MAT_ONE;
          default: e = '0;
        endcase
    endcase
    return e;
  endfunction

  function automatic coord_t pick_coord(int kind);
    coord_t v;
    case (kind)
      0: v = coord_t'($urandom);
      1: v = coord_t'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      default:
        case ($urandom_range(0, 4))
          0: v = C_MAX;
          1: v = C_MIN;
          2: v = '0;
          3: v = -1;
          default: v = 1;
        endcase
    endcase
    return v;
  endfunction

  function automatic coord_t pick_input();
    int k;
    k = $urandom_range(0, 9);
    return pick_coord(k < 6 ? 0 : (k < 9 ? 1 : 2));
  endfunction

  task automatic offer_point(rtpv_op_t op, coord_t x, coord_t y, coord_t z);
    int n;
    n = (tx_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    @(negedge clk);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {z, y, x};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // bits above 32 on the offset and target writes must be ignored
  task automatic load_config(int kind);
    settle();
    write_reg(REG_ROT_ROW0, {pick_entry(kind), pick_entry(kind), pick_entry(kind)});
    write_reg(REG_ROT_ROW1, {pick_entry(kind), pick_entry(kind), pick_entry(kind)});
    write_reg(REG_ROT_ROW2, {pick_entry(kind), pick_entry(kind), pick_entry(kind)});
    write_reg(REG_BEAM_OFFSET, {16'($urandom), pick_coord(kind)});
    write_reg(REG_TARGET_X, {16'($urandom), pick_coord(kind)});
    write_reg(REG_TARGET_Y, {16'($urandom), pick_coord(kind)});
    write_reg(REG_TARGET_Z, {16'($urandom), pick_coord(kind)});
    write_reg(REG_UNUSED, {$urandom, 16'($urandom)});
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  initial begin
    int p;
    int n;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_FWD_POINT;
    cfg_valid = 1'b0;
    cfg_index = REG_ROT_ROW0;
    cfg_data = '0;
    idle_cycles = 0;
    settings = 1;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    hold_req = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // identity after reset: zero vectors, full-scale corners
    for (int k = 0; k < 4; k++) begin
      offer_point(rtpv_op_t'(k), 0, 0, 0);
      offer_point(rtpv_op_t'(k), C_MAX, C_MIN, C_MAX);
      offer_point(rtpv_op_t'(k), C_MIN, C_MAX, C_MIN);
    end

    // extreme matrix, offset and target
    settle();
    write_reg(REG_ROT_ROW0, {3{16'h8000}});
    write_reg(REG_ROT_ROW1, {3{16'h7FFF}});
    write_reg(REG_ROT_ROW2, {16'h0001, 16'h7FFF, 16'h8000});
    write_reg(REG_BEAM_OFFSET, 48'(C_MAX));
    write_reg(REG_TARGET_X, 48'(C_MIN));
    write_reg(REG_TARGET_Y, 48'(C_MAX));
    write_reg(REG_TARGET_Z, 48'(C_MIN));
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings++;
    for (int k = 0; k < 4; k++) begin
      offer_point(rtpv_op_t'(k), C_MAX, C_MAX, C_MAX);
      offer_point(rtpv_op_t'(k), C_MIN, C_MIN, C_MIN);
    end

    for (p = 0; p < PHASES; p++) begin
      tx_gaps = (p != PHASES - 1);
      rx_gaps = (p != PHASES - 1);
      load_config(p % 3);
      for (n = 0; n < PHASE_REQS; n++) begin
        if (p == 2 && n == 20) begin
          tx_gaps = 1'b0;
          hold_req = 1'b1;
        end
        if (p == 2 && n == 60) tx_gaps = 1'b1;
        if (p == 5 && n == 50) settle();
        offer_point(rtpv_op_t'($urandom_range(0, 3)), pick_input(), pick_input(),
                    pick_input());
      end
    end

    settle();
    repeat (20) @(negedge clk);
    $display("covered %0d transforms of all four kinds under %0d register settings,",
             checked, settings);
    $display("%0d of them saturated, with stalls and back-pressure on both sides", clipped);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, pending);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
